[design/ps2mc_pkg.sv]
// shared types and constants of the ps/2 mouse cursor tracker
package ps2mc_pkg;

    // coordinate width and position after reset
    localparam int COORD_BITS_DEFAULT = 12;
    localparam int POS_X_RESET        = 400;
    localparam int POS_Y_RESET        = 300;

    // configuration registers
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 13;
    localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_BITS-1:0] VIEW_WIDTH_RESET  = 13'd800;
    localparam logic [CFG_DATA_BITS-1:0] VIEW_HEIGHT_RESET = 13'd600;

    // port widths
    localparam int RX_BITS    = 8;
    localparam int OUT_COORD  = 12;
    localparam int M_DATA_BITS = 32;

    // header bit positions
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_SYNC   = 3;
    localparam int HDR_SIGN_X = 4;
    localparam int HDR_SIGN_Y = 5;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // position in the three-byte packet
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DX     = 2'd1,
        PH_DY     = 2'd2
    } phase_t;

    // one complete packet as handed to the back end
    typedef struct packed {
        logic       right_button;
        logic       left_button;
        logic       sign_y;
        logic       sign_x;
        logic [7:0] delta_x;
        logic [7:0] delta_y;
    } pkt_t;

endpackage

[design/ps2mc_front.sv]
// byte front end: packet framing with header resync
module ps2mc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] rx_byte
    output logic              pkt_valid,
    input  logic              pkt_ready,
    output ps2mc_pkg::pkt_t   pkt_data
);

    ps2mc_pkg::phase_t phase_reg, phase_next;
    logic [7:0] header_reg;
    logic [7:0] dx_reg;
    logic       accept;
    logic       load_header;
    logic       load_dx;

    // stall the byte stream only while the queue is full
    assign s_tready = pkt_ready;
    assign accept   = s_tvalid && s_tready;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            unique case (phase_reg)
                ps2mc_pkg::PH_DX:     phase_next = ps2mc_pkg::PH_DY;
                ps2mc_pkg::PH_DY:     phase_next = ps2mc_pkg::PH_HEADER;
                default: begin
                    if (s_tdata[ps2mc_pkg::HDR_SYNC]) begin
                        phase_next = ps2mc_pkg::PH_DX;
                    end else begin
                        phase_next = ps2mc_pkg::PH_HEADER;
                    end
                end
            endcase
        end
    end

    // per-phase actions
    always_comb begin
        load_header = 1'b0;
        load_dx     = 1'b0;
        pkt_valid   = 1'b0;
        unique case (phase_reg)
            ps2mc_pkg::PH_DX: load_dx   = accept;
            ps2mc_pkg::PH_DY: pkt_valid = accept;
            default:          load_header = accept && s_tdata[ps2mc_pkg::HDR_SYNC];
        endcase
    end

    // packet record from stored header, stored x delta and current y byte
    always_comb begin
        pkt_data.right_button = header_reg[ps2mc_pkg::HDR_RIGHT];
        pkt_data.left_button  = header_reg[ps2mc_pkg::HDR_LEFT];
        pkt_data.sign_y       = header_reg[ps2mc_pkg::HDR_SIGN_Y];
        pkt_data.sign_x       = header_reg[ps2mc_pkg::HDR_SIGN_X];
        pkt_data.delta_x      = dx_reg;
        pkt_data.delta_y      = s_tdata;
    end

    // phase register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ps2mc_pkg::PH_HEADER;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // header and x delta hold
    always_ff @(posedge aclk) begin
        if (load_header) begin
            header_reg <= s_tdata;
        end
        if (load_dx) begin
            dx_reg <= s_tdata;
        end
    end

    // a packet leaves only on the y byte
    a_push_on_dy: assert property (@(posedge aclk) disable iff (!aresetn)
        pkt_valid |-> (phase_reg == ps2mc_pkg::PH_DY) && (phase_next == ps2mc_pkg::PH_HEADER))
        else $error("packet pushed outside y phase");

endmodule

[design/ps2mc_queue.sv]
// short register queue between front and back end
module ps2mc_queue #(
    parameter int DEPTH = ps2mc_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  ps2mc_pkg::pkt_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output ps2mc_pkg::pkt_t pop_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    ps2mc_pkg::pkt_t       entry_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != CNT_BITS'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and count update, wrapping at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("queue count above depth");

    a_count_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

endmodule

[design/ps2mc_back.sv]
// back end: cursor update, viewport clamp and output register
module ps2mc_back #(
    parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [ps2mc_pkg::CFG_DATA_BITS-1:0]  view_width,
    input  logic [ps2mc_pkg::CFG_DATA_BITS-1:0]  view_height,
    input  logic                                 pkt_valid,
    output logic                                 pkt_ready,
    input  ps2mc_pkg::pkt_t                      pkt_data,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ps2mc_pkg::M_DATA_BITS-1:0]    m_tdata
);

    localparam int CAP = 1 << COORD_BITS;
    localparam int EW  = ((COORD_BITS + 2) > (ps2mc_pkg::CFG_DATA_BITS + 1))
                         ? (COORD_BITS + 2) : (ps2mc_pkg::CFG_DATA_BITS + 1);
    localparam int SW  = COORD_BITS + 2;
    localparam int OC  = ps2mc_pkg::OUT_COORD;

    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next;
    logic [COORD_BITS-1:0] lim_x, lim_y;
    logic                  out_valid_reg;
    logic [OC-1:0]         out_x_reg, out_y_reg;
    logic                  out_left_reg, out_right_reg;
    logic                  pop;
    logic signed [8:0]     dx9, dy9;
    logic signed [SW-1:0]  sum_x, sum_y;

    // take a packet when the output register is free or draining
    assign pkt_ready = !out_valid_reg || m_tready;
    assign pop       = pkt_valid && pkt_ready;

    // largest coordinate from a viewport size
    function automatic logic [COORD_BITS-1:0] limit_of(
        input logic [ps2mc_pkg::CFG_DATA_BITS-1:0] size
    );
        logic [EW-1:0] s;
        s = EW'(size);
        if (s == '0) begin
            limit_of = '0;
        end else if (s > EW'(CAP)) begin
            limit_of = COORD_BITS'(CAP - 1);
        end else begin
            limit_of = COORD_BITS'(s - 1'b1);
        end
    endfunction

    // clamp a signed sum into zero to limit
    function automatic logic [COORD_BITS-1:0] clamp(
        input logic signed [SW-1:0] v,
        input logic [COORD_BITS-1:0] hi
    );
        if (v[SW-1]) begin
            clamp = '0;
        end else if (v[SW-2:0] > (SW-1)'(hi)) begin
            clamp = hi;
        end else begin
            clamp = v[COORD_BITS-1:0];
        end
    endfunction

    // new position: x added, y subtracted (screen y grows downward)
    always_comb begin
        lim_x = limit_of(view_width);
        lim_y = limit_of(view_height);
        dx9   = {pkt_data.sign_x, pkt_data.delta_x};
        dy9   = {pkt_data.sign_y, pkt_data.delta_y};
        sum_x = $signed({2'b00, pos_x_reg}) + SW'(dx9);
        sum_y = $signed({2'b00, pos_y_reg}) - SW'(dy9);
        pos_x_next = clamp(sum_x, lim_x);
        pos_y_next = clamp(sum_y, lim_y);
    end

    // position and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg     <= COORD_BITS'(ps2mc_pkg::POS_X_RESET);
            pos_y_reg     <= COORD_BITS'(ps2mc_pkg::POS_Y_RESET);
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
            end
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            out_x_reg     <= OC'(pos_x_next);
            out_y_reg     <= OC'(pos_y_next);
            out_left_reg  <= pkt_data.left_button;
            out_right_reg <= pkt_data.right_button;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ps2mc_pkg::M_DATA_BITS - 2 * OC - 2){1'b0}},
                       out_right_reg, out_left_reg, out_y_reg, out_x_reg};

    a_pop_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_tvalid)
        else $error("taken packet not presented");

    a_out_tracks_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (out_x_reg == OC'(pos_x_reg)) && (out_y_reg == OC'(pos_y_reg)))
        else $error("output differs from tracked position");

endmodule

[design/ps2_mouse_cursor_tracker_core.sv]
// top level of the ps/2 mouse cursor tracker
//
// channel  | dir | ports                         | item
// ---------+-----+-------------------------------+----------------------------------------
// s_       | in  | s_tvalid s_tready s_tdata[7:0] | rx_byte
// m_       | out | m_tvalid m_tready m_tdata[31:0]| cursor_x, cursor_y, left, right buttons
// cfg_     | in  | cfg_valid cfg_ready cfg_index  | 0 view_width, 1 view_height
//          |     | cfg_data[12:0]                 |
//
// one byte per cycle while the packet queue has room; a packet's third byte writes
// the queue entry, and the output register is loaded when the back takes that entry
// the front stalls only when the two-entry packet queue is full; the back takes
// a packet whenever its output register is empty or being read
// synchronous active-low reset: phase to header, cursor to (400, 300), viewport
// to 800 x 600; configuration is always ready, unknown indexes are dropped
module ps2_mouse_cursor_tracker_core #(
    parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ps2mc_pkg::RX_BITS-1:0]       s_tdata,    // [7:0] rx_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [11:0] cursor_x, [23:12] cursor_y, [24] left_button, [25] right_button
    output logic [ps2mc_pkg::M_DATA_BITS-1:0]   m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ps2mc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ps2mc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    logic [ps2mc_pkg::CFG_DATA_BITS-1:0] view_width_reg;
    logic [ps2mc_pkg::CFG_DATA_BITS-1:0] view_height_reg;
    logic            fq_valid, fq_ready;
    ps2mc_pkg::pkt_t fq_data;
    logic            qb_valid, qb_ready;
    ps2mc_pkg::pkt_t qb_data;

    assign cfg_ready = 1'b1;

    // viewport registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_width_reg  <= ps2mc_pkg::VIEW_WIDTH_RESET;
            view_height_reg <= ps2mc_pkg::VIEW_HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ps2mc_pkg::REG_VIEW_WIDTH:  view_width_reg  <= cfg_data;
                ps2mc_pkg::REG_VIEW_HEIGHT: view_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // packet framing
    ps2mc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .pkt_valid (fq_valid),
        .pkt_ready (fq_ready),
        .pkt_data  (fq_data)
    );

    // packet queue
    ps2mc_queue #(
        .DEPTH (ps2mc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    // cursor update
    ps2mc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .view_width  (view_width_reg),
        .view_height (view_height_reg),
        .pkt_valid   (qb_valid),
        .pkt_ready   (qb_ready),
        .pkt_data    (qb_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

[sim/cursor_track_monitor.sv]
`timescale 1ns / 1ps
// monitor that predicts cursor reports from observed mouse bytes and checks the block output
module cursor_track_monitor #(
    parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [ps2mc_pkg::RX_BITS-1:0]       s_tdata,    // [7:0] rx_byte
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // [11:0] cursor_x, [23:12] cursor_y, [24] left_button, [25] right_button
    input  logic [ps2mc_pkg::M_DATA_BITS-1:0]   m_tdata,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [ps2mc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ps2mc_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output int                                  pending,
    output int                                  fail_count
);
    import ps2mc_pkg::*;

    localparam int COORD_MASK = (1 << COORD_BITS) - 1;

    // one cursor report, packed as on m_tdata
    typedef struct packed {
        logic                 right_button;
        logic                 left_button;
        logic [OUT_COORD-1:0] cursor_y;
        logic [OUT_COORD-1:0] cursor_x;
    } cursor_report_t;

    // predicted state of the block
    logic [CFG_DATA_BITS-1:0] view_width;
    logic [CFG_DATA_BITS-1:0] view_height;
    phase_t                   rx_phase;
    logic [7:0]               header_byte;
    logic [7:0]               delta_x_byte;
    int                       cur_x;
    int                       cur_y;

    cursor_report_t expected_reports [$];
    int             mismatches = 0;

    assign fail_count = mismatches;

    // largest coordinate a viewport size allows
    function automatic int coord_limit(input logic [CFG_DATA_BITS-1:0] size);
        int s;
        s = int'(size);
        if (s == 0) s = 1;
        if (s > (1 << COORD_BITS)) s = 1 << COORD_BITS;
        return s - 1;
    endfunction

    function automatic int saturate(input int v, input int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    // 8-bit low byte plus header sign bit as a 9-bit two's complement value
    function automatic int signed_delta(input logic [7:0] low, input logic negative);
        return negative ? int'(low) - 256 : int'(low);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // advance the packet decoder by one byte, queue a report on the third
    task automatic track_rx_byte(input logic [7:0] b);
        cursor_report_t rep;
        case (rx_phase)
            PH_DX: begin
                delta_x_byte = b;
                rx_phase     = PH_DY;
            end
            PH_DY: begin
                rx_phase = PH_HEADER;
                cur_x = saturate(cur_x + signed_delta(delta_x_byte, header_byte[HDR_SIGN_X]),
                                 coord_limit(view_width)) & COORD_MASK;
                cur_y = saturate(cur_y - signed_delta(b, header_byte[HDR_SIGN_Y]),
                                 coord_limit(view_height)) & COORD_MASK;
                rep.cursor_x     = cur_x[OUT_COORD-1:0];
                rep.cursor_y     = cur_y[OUT_COORD-1:0];
                rep.left_button  = header_byte[HDR_LEFT];
                rep.right_button = header_byte[HDR_RIGHT];
                expected_reports.push_back(rep);
            end
            default: begin
                // bytes without the sync bit are dropped to regain packet alignment
                if (b[HDR_SYNC]) begin
                    header_byte = b;
                    rx_phase    = PH_DX;
                end else begin
                    rx_phase = PH_HEADER;
                end
            end
        endcase
    endtask

    // compare one output item with the oldest expected report
    task automatic check_report(input logic [M_DATA_BITS-1:0] word);
        cursor_report_t want;
        cursor_report_t got;
        got = word[$bits(cursor_report_t)-1:0];
        if (expected_reports.size() == 0) begin
            report_mismatch("cursor report with none expected", int'(word), 0);
        end else begin
            want = expected_reports.pop_front();
            if (got.cursor_x != want.cursor_x)
                report_mismatch("cursor_x", got.cursor_x, want.cursor_x);
            if (got.cursor_y != want.cursor_y)
                report_mismatch("cursor_y", got.cursor_y, want.cursor_y);
            if (got.left_button != want.left_button)
                report_mismatch("left_button", got.left_button, want.left_button);
            if (got.right_button != want.right_button)
                report_mismatch("right_button", got.right_button, want.right_button);
        end
    endtask

    // watch all three channels at each edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            view_width   = VIEW_WIDTH_RESET;
            view_height  = VIEW_HEIGHT_RESET;
            rx_phase     = PH_HEADER;
            header_byte  = '0;
            delta_x_byte = '0;
            cur_x        = POS_X_RESET & COORD_MASK;
            cur_y        = POS_Y_RESET & COORD_MASK;
            expected_reports.delete();
        end else begin
            if (m_tvalid && m_tready) check_report(m_tdata);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_VIEW_WIDTH: begin
                        view_width = cfg_data;
                    end
                    REG_VIEW_HEIGHT: begin
                        view_height = cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) track_rx_byte(s_tdata);
        end
        pending <= expected_reports.size();
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// top of the cursor tracker testbench: clock, reset, stimulus and verdict
module testbench;
    import ps2mc_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;
    localparam int SEGMENTS         = 8;
    localparam int UNITS_PER_SEG    = 30;
    localparam int SETTLE_CYCLES    = 6;

    // opening bytes: dropped non-headers, still packet, extreme deltas, saturation
    localparam logic [7:0] OPENING_BYTES [26] = '{
        8'h00, 8'hF7,
        8'h08, 8'h00, 8'h00,
        8'h3B, 8'h00, 8'h00,
        8'h09, 8'hFF, 8'h7F,
        8'hFF, 8'hFF, 8'hFF,
        8'h18, 8'h00, 8'h80,
        8'h18, 8'h00, 8'h00,
        8'h28, 8'h7F, 8'h00,
        8'h2A, 8'hFF, 8'h00
    };

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [RX_BITS-1:0]       s_tdata   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [M_DATA_BITS-1:0]   m_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    int pending;
    int fail_count;
    int send_idle  = 0;
    int recv_stall = 0;

    ps2_mouse_cursor_tracker_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cursor_track_monitor monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    // run limit
    initial begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // send one mouse byte, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // hold the input off until every report has come and the pipeline is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed packets with random content, some loose bytes
    task automatic send_packet_or_noise();
        logic [7:0] hdr;
        hdr = 8'($urandom_range(255)) | (8'h01 << HDR_SYNC);
        if ($urandom_range(99) < 85) begin
            send_byte(hdr);
            send_byte(8'($urandom_range(255)));
            send_byte(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
        end
    endtask

    // viewport for each random segment, extremes included
    task automatic set_viewport(input int seg);
        case (seg)
            0: begin
                write_cfg(REG_VIEW_WIDTH, 13'd800);
                write_cfg(REG_VIEW_HEIGHT, 13'd600);
            end
            1: begin
                write_cfg(REG_VIEW_WIDTH, 13'd1);
                write_cfg(REG_VIEW_HEIGHT, 13'd4096);
            end
            2: begin
                write_cfg(REG_VIEW_WIDTH, 13'd4096);
                write_cfg(REG_VIEW_HEIGHT, 13'd1);
            end
            3: begin
                // unknown indexes must leave the viewport alone
                write_cfg(REG_VIEW_WIDTH, 13'd8191);
                write_cfg(REG_VIEW_HEIGHT, 13'd0);
                write_cfg(REG_SPARE_A, 13'($urandom_range(8191)));
                write_cfg(REG_SPARE_B, 13'($urandom_range(8191)));
            end
            4: begin
                write_cfg(REG_VIEW_WIDTH, 13'($urandom_range(1, 4096)));
                write_cfg(REG_VIEW_HEIGHT, 13'($urandom_range(1, 4096)));
            end
            5: begin
                write_cfg(REG_VIEW_WIDTH, 13'd5000);
                write_cfg(REG_VIEW_HEIGHT, 13'd8191);
            end
            6: begin
                write_cfg(REG_VIEW_WIDTH, 13'($urandom_range(1, 64)));
                write_cfg(REG_VIEW_HEIGHT, 13'($urandom_range(1, 64)));
            end
            default: begin
                write_cfg(REG_VIEW_WIDTH, 13'd640);
                write_cfg(REG_VIEW_HEIGHT, 13'd480);
            end
        endcase
    endtask

    // stimulus and verdict
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at the reset viewport
        foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);
        settle();

        // zero-sized viewport pins the cursor at the origin
        write_cfg(REG_VIEW_WIDTH, 13'd0);
        write_cfg(REG_VIEW_HEIGHT, 13'd0);
        send_byte(8'h0B);
        send_byte(8'h01);
        send_byte(8'hFF);
        settle();

        // random segments, each with its own viewport and idle pattern
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            set_viewport(seg);
            case (seg % 4)
                0: begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1: begin
                    send_idle  = 74;
                    recv_stall = 0;
                end
                2: begin
                    send_idle  = 0;
                    recv_stall = 74;
                end
                default: begin
                    send_idle  = 35;
                    recv_stall = 35;
                end
            endcase
            for (int k = 0; k < UNITS_PER_SEG; k++) begin
                if (k == UNITS_PER_SEG / 2) settle();
                send_packet_or_noise();
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
